// ===== rtl/modular_exponentiation_unit_assert.svh =====
// Assertion macros shared by the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/mexp_pkg.sv =====
// Shared types and constants of the modular exponentiation unit.
package mexp_pkg;

   localparam int EXP_BITS = 63;
   localparam int EXP_PORT_W = 63;
   localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;
   localparam int DATA_W = 30;
   localparam int WORD_W = 32;
   localparam int PROD_W = 64;
   localparam int STEP_W = 4;

   localparam logic [WORD_W-1:0] MOD_WORD = 32'd1000000007;
   localparam logic [DATA_W-1:0] MOD_DATA = MOD_WORD[DATA_W-1:0];
   localparam logic [WORD_W-1:0] MOD_DOUBLE = 32'd2000000014;
   localparam logic [WORD_W-1:0] MOD_TRIPLE = 32'd3000000021;

   // Barrett constant floor(2^60 / modulus)
   localparam logic [PROD_W-1:0] BARRETT_MU_WIDE = (64'd1 << 60) / 64'd1000000007;
   localparam logic [WORD_W-1:0] BARRETT_MU = BARRETT_MU_WIDE[WORD_W-1:0];

   typedef enum logic [STEP_W-1:0] {
      STEP_TAKE,
      STEP_SQ_MUL,
      STEP_SQ_QUOT,
      STEP_SQ_BACK,
      STEP_SQ_SUB,
      STEP_SQ_FIX,
      STEP_BM_MUL,
      STEP_BM_QUOT,
      STEP_BM_BACK,
      STEP_BM_SUB,
      STEP_BM_FIX,
      STEP_NEXT,
      STEP_EMIT
   } step_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SQR,
      MUL_BASE,
      MUL_QUOT,
      MUL_BACK
   } mul_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_OUT_BUSY
   } hold_type;

   typedef enum logic [1:0] {
      BR_NEVER,
      BR_ALWAYS,
      BR_BIT_CLEAR,
      BR_MORE_BITS
   } branch_type;

   typedef struct packed {
      logic       take;
      hold_type   hold;
      mul_type    mul_op;
      logic       save_x;
      logic       do_sub;
      logic       do_fix;
      logic       shift_exp;
      logic       emit;
      branch_type branch;
      step_type   target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_busy;
      logic exp_msb;
      logic more_bits;
   } stat_type;

endpackage

// ===== rtl/mexp_useq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
module mexp_useq (
   input  logic               clock,
   input  logic               reset,
   input  mexp_pkg::stat_type stat,
   output mexp_pkg::ctrl_type cw
);
   import mexp_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     hold;
   logic     taken;

   // Control store
   always_comb begin
      cw.take      = 1'b0;
      cw.hold      = HOLD_NONE;
      cw.mul_op    = MUL_NONE;
      cw.save_x    = 1'b0;
      cw.do_sub    = 1'b0;
      cw.do_fix    = 1'b0;
      cw.shift_exp = 1'b0;
      cw.emit      = 1'b0;
      cw.branch    = BR_NEVER;
      cw.target    = STEP_TAKE;
      unique case (pc_ff)
         STEP_TAKE: begin
            cw.take = 1'b1;
            cw.hold = HOLD_NO_REQ;
         end
         STEP_SQ_MUL:  cw.mul_op = MUL_SQR;
         STEP_SQ_QUOT: begin
            cw.mul_op = MUL_QUOT;
            cw.save_x = 1'b1;
         end
         STEP_SQ_BACK: cw.mul_op = MUL_BACK;
         STEP_SQ_SUB:  cw.do_sub = 1'b1;
         STEP_SQ_FIX: begin
            cw.do_fix = 1'b1;
            cw.branch = BR_BIT_CLEAR;
            cw.target = STEP_NEXT;
         end
         STEP_BM_MUL:  cw.mul_op = MUL_BASE;
         STEP_BM_QUOT: begin
            cw.mul_op = MUL_QUOT;
            cw.save_x = 1'b1;
         end
         STEP_BM_BACK: cw.mul_op = MUL_BACK;
         STEP_BM_SUB:  cw.do_sub = 1'b1;
         STEP_BM_FIX:  cw.do_fix = 1'b1;
         STEP_NEXT: begin
            cw.shift_exp = 1'b1;
            cw.branch    = BR_MORE_BITS;
            cw.target    = STEP_SQ_MUL;
         end
         STEP_EMIT: begin
            cw.emit   = 1'b1;
            cw.hold   = HOLD_OUT_BUSY;
            cw.branch = BR_ALWAYS;
            cw.target = STEP_TAKE;
         end
         default: begin
            cw.branch = BR_ALWAYS;
            cw.target = STEP_TAKE;
         end
      endcase
   end

   // Next step
   always_comb begin
      unique case (cw.hold)
         HOLD_NO_REQ:   hold = ~stat.req_valid;
         HOLD_OUT_BUSY: hold = stat.out_busy;
         default:       hold = 1'b0;
      endcase
      unique case (cw.branch)
         BR_ALWAYS:    taken = 1'b1;
         BR_BIT_CLEAR: taken = ~stat.exp_msb;
         BR_MORE_BITS: taken = stat.more_bits;
         default:      taken = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = cw.target;
      end else begin
         pc_in = step_type'(STEP_W'(pc_ff) + STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_TAKE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== rtl/mexp_dpath.sv =====
// Datapath: shared multiplier, Barrett reduction registers, exponent shifter, result register.
`include "modular_exponentiation_unit_assert.svh"

module mexp_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  mexp_pkg::ctrl_type                  cw,
   input  logic                                req_valid,
   input  logic [mexp_pkg::DATA_W-1:0]         req_base,
   input  logic [mexp_pkg::EXP_PORT_W-1:0]     req_exponent,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [mexp_pkg::DATA_W-1:0]         rsp_power,
   output mexp_pkg::stat_type                  stat
);
   import mexp_pkg::*;

   logic                accept;
   logic                emit_go;
   logic [DATA_W-1:0]   base_red;
   logic [WORD_W-1:0]   mul_a;
   logic [WORD_W-1:0]   mul_b;
   logic [PROD_W-1:0]   prod_in;
   logic [WORD_W-1:0]   r_in;
   logic [WORD_W-1:0]   fix_val;

   logic [DATA_W-1:0]   base_ff;
   logic [DATA_W-1:0]   acc_ff;
   logic [EXP_BITS-1:0] exp_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [WORD_W-1:0]   x_ff;
   logic [WORD_W-1:0]   r_ff;
   logic                rsp_valid_ff;
   logic [DATA_W-1:0]   rsp_power_ff;

   assign accept   = req_valid & cw.take;
   assign base_red = (req_base >= MOD_DATA) ? req_base - MOD_DATA : req_base;

   assign stat.req_valid = req_valid;
   assign stat.out_busy  = rsp_valid_ff & rsp_stall;
   assign stat.exp_msb   = exp_ff[EXP_BITS-1];
   assign stat.more_bits = (cnt_ff != '0);

   assign emit_go = cw.emit & ~stat.out_busy;

   // Operand select for the shared multiplier
   always_comb begin
      unique case (cw.mul_op)
         MUL_SQR: begin
            mul_a = WORD_W'(acc_ff);
            mul_b = WORD_W'(acc_ff);
         end
         MUL_BASE: begin
            mul_a = WORD_W'(acc_ff);
            mul_b = WORD_W'(base_ff);
         end
         MUL_QUOT: begin
            // q1 = x >> 29
            mul_a = WORD_W'(prod_ff[2*DATA_W-1:DATA_W-1]);
            mul_b = BARRETT_MU;
         end
         MUL_BACK: begin
            // q3 = q1 * mu >> 31
            mul_a = WORD_W'(prod_ff[2*DATA_W+1:DATA_W+1]);
            mul_b = MOD_WORD;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Remainder lies below three moduli; low word is exact
   assign r_in = x_ff - prod_ff[WORD_W-1:0];

   always_comb begin
      if (r_ff >= MOD_DOUBLE) begin
         fix_val = r_ff - MOD_DOUBLE;
      end else if (r_ff >= MOD_WORD) begin
         fix_val = r_ff - MOD_WORD;
      end else begin
         fix_val = r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff <= base_red;
         exp_ff  <= req_exponent[EXP_BITS-1:0];
         cnt_ff  <= CNT_W'(EXP_BITS - 1);
         acc_ff  <= DATA_W'(1);
      end else begin
         if (cw.shift_exp) begin
            exp_ff <= exp_ff << 1;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         if (cw.do_fix) begin
            acc_ff <= fix_val[DATA_W-1:0];
         end
      end
      if (cw.mul_op != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (cw.save_x) begin
         x_ff <= prod_ff[WORD_W-1:0];
      end
      if (cw.do_sub) begin
         r_ff <= r_in;
      end
      if (emit_go) begin
         rsp_power_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

   `MEXP_ASSERT_NEXT(a_base_reduced, accept, base_ff < MOD_DATA, "base not reduced")
   `MEXP_ASSERT_NEXT(a_barrett_bound, cw.do_sub, r_ff < MOD_TRIPLE, "Barrett remainder too large")
   `MEXP_ASSERT_NEXT(a_acc_reduced, cw.do_fix, acc_ff < MOD_DATA, "accumulator not reduced")

endmodule

// ===== rtl/modular_exponentiation_unit.sv =====
// Top level of the modular exponentiation unit.
// Computes base^exponent mod 1000000007 by square-and-multiply, scanning all 63 exponent
// bits from the top. One request is worked at a time. Each modular product takes five
// steps on a single 32x32 multiplier (product, then Barrett reduction with two more
// multiplications, a subtract and a final correction). Each exponent bit takes a squaring
// and a shift of the exponent, plus a multiplication by the base when the bit is set.
// A zero exponent gives 1, and a base at or above the modulus is reduced on entry. The
// next request is taken as soon as the sequencer is back at its idle step, even while
// the previous result still waits under rsp_stall.
module modular_exponentiation_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mexp_pkg::DATA_W-1:0]     req_base,
   input  logic [mexp_pkg::EXP_PORT_W-1:0] req_exponent,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mexp_pkg::DATA_W-1:0]     rsp_power
);
   import mexp_pkg::*;

   ctrl_type cw;
   stat_type stat;

   assign req_stall = ~cw.take;

   mexp_useq u_useq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cw    (cw)
   );

   mexp_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cw           (cw),
      .req_valid    (req_valid),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_power    (rsp_power),
      .stat         (stat)
   );

endmodule

// ===== dv/tb_modular_exponentiation_unit.sv =====
// Testbench of the modular exponentiation unit: directed and random requests with a predictor.
module tb_modular_exponentiation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import mexp_pkg::*;

   localparam longint unsigned PRIME = 64'd1000000007;
   localparam int RANDOM_PER_PHASE = 645;
   localparam longint CYCLE_LIMIT = 12_000_000;
   // leave room for a request and the stalls behind it
   localparam int DRAIN_CYCLES = 800;
   localparam logic [EXP_PORT_W-1:0] EXP_ALL_ONES = '1;
   localparam logic [DATA_W-1:0] BASE_ALL_ONES = '1;

   typedef struct packed {
      logic [DATA_W-1:0]     base;
      logic [EXP_PORT_W-1:0] exponent;
      logic [DATA_W-1:0]     power;
   } power_entry_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_base = '0;
   logic [EXP_PORT_W-1:0] req_exponent = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_W-1:0]     rsp_power;

   power_entry_type pending_powers[$];
   int         send_idle_pct = 0;
   int         rsp_stall_pct = 0;
   int         fail_count = 0;
   int         results_checked = 0;
   int         directed_sent = 0;
   int         random_sent = 0;
   longint     cycle_count = 0;

   modular_exponentiation_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_power    (rsp_power)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [DATA_W-1:0] predict_power(input logic [DATA_W-1:0] base,
                                                       input logic [EXP_PORT_W-1:0] exponent);
      logic [63:0] running;
      logic [63:0] factor;
      int          bit_idx;
      factor = 64'(base);
      // one subtraction brings any 30-bit base below the modulus
      if (factor >= PRIME) factor = factor - PRIME;
      running = 64'd1;
      for (bit_idx = EXP_BITS - 1; bit_idx >= 0; bit_idx--) begin
         running = (running * running) % PRIME;
         if (exponent[bit_idx]) running = (running * factor) % PRIME;
      end
      return running[DATA_W-1:0];
   endfunction

   task automatic send_request(input logic [DATA_W-1:0] base,
                               input logic [EXP_PORT_W-1:0] exponent);
      power_entry_type entry;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do @(posedge clock); while (!(req_valid && !req_stall));
      entry.base     = base;
      entry.exponent = exponent;
      entry.power    = predict_power(base, exponent);
      pending_powers = {pending_powers, entry};
   endtask

   task automatic test_zero_exponent();
      send_request('0, '0);
      send_request(30'd1, '0);
      send_request(MOD_DATA - 30'd1, '0);
      send_request(BASE_ALL_ONES, '0);
      directed_sent += 4;
   endtask

   task automatic test_unreduced_base();
      // bases at and above the modulus fold back to 0, 1 and 73741816
      send_request(MOD_DATA, 63'd5);
      send_request(MOD_DATA + 30'd1, 63'd12345);
      send_request(BASE_ALL_ONES, 63'd1);
      send_request(BASE_ALL_ONES, EXP_ALL_ONES);
      send_request(MOD_DATA, EXP_ALL_ONES);
      directed_sent += 5;
   endtask

   task automatic test_exponent_extremes();
      send_request('0, 63'd1);
      send_request('0, EXP_ALL_ONES);
      send_request(30'd1, EXP_ALL_ONES);
      send_request(30'd2, 63'd1 << 62);
      send_request(30'd2, 63'd62);
      send_request(MOD_DATA - 30'd1, 63'd1);
      send_request(MOD_DATA - 30'd1, 63'd2);
      send_request(MOD_DATA - 30'd1, EXP_ALL_ONES);
      // Fermat: a^(p-1) = 1
      send_request(30'd7, 63'd1000000006);
      send_request(30'd123456789, 63'h2AAA_AAAA_AAAA_AAAA);
      send_request(30'd987654321, 63'h5555_5555_5555_5555);
      directed_sent += 11;
   endtask

   task automatic test_random_powers(input int sender_pct, input int receiver_pct);
      logic [DATA_W-1:0]     base;
      logic [EXP_PORT_W-1:0] exponent;
      int                    kind;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      repeat (RANDOM_PER_PHASE) begin
         if ($urandom_range(4) == 0) base = DATA_W'($urandom);
         else base = DATA_W'($urandom_range(1000000006, 0));
         kind = int'($urandom_range(9));
         case (kind)
            0: begin
               exponent = EXP_PORT_W'($urandom_range(15));
            end
            1: begin
               exponent = EXP_ALL_ONES >> $urandom_range(62);
            end
            2: begin
               exponent = 63'd1 << $urandom_range(62);
            end
            default: begin
               exponent = EXP_PORT_W'({$urandom, $urandom});
            end
         endcase
         send_request(base, exponent);
         random_sent++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (rsp_stall_pct > 0) && ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      power_entry_type entry;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_powers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual power %0d",
                     $time, rsp_power);
            fail_count++;
         end else begin
            entry = pending_powers.pop_front();
            results_checked++;
            if (rsp_power !== entry.power) begin
               $display("%0t: base %0d exponent %0h: expected power %0d, actual %0d",
                        $time, entry.base, entry.exponent, entry.power, rsp_power);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, pending_powers.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 27;
      rsp_stall_pct = 78;
      test_zero_exponent();
      test_unreduced_base();
      test_exponent_extremes();
      test_random_powers(27, 78);
      test_random_powers(78, 27);
      test_random_powers(0, 0);
      req_valid <= 1'b0;
      while (pending_powers.size() != 0) @(posedge clock);
      // hold a while longer to catch any stray result
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d directed and %0d random requests across three idle/stall mixes.",
               directed_sent, random_sent);
      $display("Checked %0d results in %0d cycles, %0d mismatches.",
               results_checked, cycle_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== modular_exponentiation_unit.f =====
+incdir+rtl
rtl/mexp_pkg.sv
rtl/mexp_useq.sv
rtl/mexp_dpath.sv
rtl/modular_exponentiation_unit.sv
dv/tb_modular_exponentiation_unit.sv
